// File: rtl/metadata_mode_dedup_macros.svh
// Assertion macros for the metadata mode dedup block.
`ifndef METADATA_MODE_DEDUP_MACROS_SVH
`define METADATA_MODE_DEDUP_MACROS_SVH
`ifndef SYNTHESIS
// Plain implication checked every clock, off during reset.
`define MMD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define MMD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MMD_ASSERT_NOW(lbl, ante, cons, msg)
`define MMD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/mmd_pkg.sv
// Shared types for the metadata mode dedup block.
`default_nettype none
package mmd_pkg;

   typedef struct packed {
      logic [31:0] stamp;
      logic [31:0] logger;
      logic [31:0] cell_id;
   } tuple_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_COUNT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_req;   // an entry is being stored this cycle
      logic count_en;   // tokens advance and collect matches
      logic scan_en;    // tokens advance without counting
      logic shift_en;   // stored entries rotate toward cell 0
      logic clear;      // end of set: drop all entries
   } cell_ctrl_type;

endpackage
`default_nettype wire

// File: rtl/metadata_mode_dedup.sv
// Top level of the metadata mode dedup block: control, cell chain and result register.
`default_nettype none
`include "metadata_mode_dedup_macros.svh"
// Collects up to MAX_ITEMS metadata tuples, one per cycle while req_stall is
// low, into a ring of cells; the transaction with last_item closes the set. A
// token holding each entry's tuple then travels once around the ring and
// counts its matches, and a second round reads the tokens past cell 0 to
// pick the most frequent tuple, earliest on ties. Results then leave one per
// cycle while the result side does not stall, in load order as the stored
// entries rotate past cell 0. The result register lets the next set start
// loading while the final result waits. A set that overflows the ring yields
// a single out-of-bounds result right after its last transaction.
module metadata_mode_dedup
   import mmd_pkg::*;
#(
   parameter int MAX_ITEMS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [31:0] req_stamp,
   input  wire logic [31:0] req_logger,
   input  wire logic [31:0] req_cell_req,
   input  wire logic        req_present,
   input  wire logic        req_last_item,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [4:0]  rsp_entry_index,
   output      logic        rsp_keeps_own,
   output      logic        rsp_shared_valid,
   output      logic [31:0] rsp_shared_stamp,
   output      logic [31:0] rsp_shared_logger,
   output      logic [31:0] rsp_shared_cell,
   output      logic [5:0]  rsp_repeat_count,
   output      logic        rsp_status,
   output      logic        rsp_last_result
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] best_cnt_ff, best_cnt_in;
   tuple_type        best_tuple_ff, best_tuple_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [4:0]       rsp_entry_index_ff, rsp_entry_index_in;
   logic             rsp_keeps_own_ff, rsp_keeps_own_in;
   logic             rsp_shared_valid_ff, rsp_shared_valid_in;
   tuple_type        rsp_shared_ff, rsp_shared_in;
   logic [5:0]       rsp_repeat_count_ff, rsp_repeat_count_in;
   logic             rsp_status_ff, rsp_status_in;
   logic             rsp_last_result_ff, rsp_last_result_in;

   cell_ctrl_type    ctrl;
   tuple_type        req_tuple;
   logic             req_take;
   logic             full;
   logic             oob_close;
   logic             set_close;
   logic             rsp_free;
   logic             emit_load;
   logic             emit_last;
   logic             step_last;
   logic             shared;
   logic [31:0]      idx_wide;
   logic [31:0]      rep_wide;

   logic             cell_valid   [MAX_ITEMS];
   tuple_type        cell_tuple   [MAX_ITEMS];
   logic             cell_present [MAX_ITEMS];
   tuple_type        tok_tuple    [MAX_ITEMS];
   logic             tok_valid    [MAX_ITEMS];
   logic [CNT_W-1:0] tok_cnt      [MAX_ITEMS];

   assign req_tuple = '{stamp: req_stamp, logger: req_logger, cell_id: req_cell_req};
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // closing transaction may need the result register for the out-of-bounds result
   assign req_stall = (state_ff != ST_LOAD) || (req_last_item && !rsp_free);
   assign req_take  = req_valid && !req_stall;
   assign full      = (cnt_ff == CNT_W'(MAX_ITEMS));
   assign oob_close = req_take && req_last_item && (ovf_ff || full);
   assign set_close = req_take && req_last_item && !(ovf_ff || full);
   assign step_last = (step_ff == CNT_W'(MAX_ITEMS - 1));
   assign emit_load = (state_ff == ST_EMIT) && rsp_free;
   assign emit_last = (step_ff == cnt_ff - CNT_W'(1));
   assign shared    = (best_cnt_ff > CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (set_close) state_in = ST_COUNT;
         ST_COUNT: if (step_last) state_in = ST_SCAN;
         ST_SCAN:  if (step_last) state_in = ST_EMIT;
         ST_EMIT:  if (emit_load && emit_last) state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   // chain control
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_LOAD: begin
            ctrl.load_req = req_take && !full;
            ctrl.clear    = oob_close;
         end
         ST_COUNT: ctrl.count_en = 1'b1;
         ST_SCAN:  ctrl.scan_en  = 1'b1;
         ST_EMIT: begin
            ctrl.shift_en = emit_load;
            ctrl.clear    = emit_load && emit_last;
         end
         default: ctrl = '0;
      endcase
   end

   // set bookkeeping and mode selection
   always_comb begin
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      step_in       = step_ff;
      best_cnt_in   = best_cnt_ff;
      best_tuple_in = best_tuple_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (full) ovf_in = 1'b1;
               else      cnt_in = cnt_ff + CNT_W'(1);
            end
            if (oob_close) begin
               cnt_in = '0;
               ovf_in = 1'b0;
            end
            step_in     = '0;
            best_cnt_in = CNT_W'(1);
         end
         ST_COUNT: step_in = step_last ? '0 : step_ff + CNT_W'(1);
         ST_SCAN: begin
            step_in = step_last ? '0 : step_ff + CNT_W'(1);
            // token at cell 0 belongs to entry step_ff; strictly larger wins
            if (tok_valid[0] && (tok_cnt[0] > best_cnt_ff)) begin
               best_cnt_in   = tok_cnt[0];
               best_tuple_in = tok_tuple[0];
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               step_in = step_ff + CNT_W'(1);
               if (emit_last) begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: step_in = '0;
      endcase
   end

   assign idx_wide = 32'(step_ff);
   assign rep_wide = 32'(best_cnt_ff);

   // result register
   always_comb begin
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_entry_index_in  = rsp_entry_index_ff;
      rsp_keeps_own_in    = rsp_keeps_own_ff;
      rsp_shared_valid_in = rsp_shared_valid_ff;
      rsp_shared_in       = rsp_shared_ff;
      rsp_repeat_count_in = rsp_repeat_count_ff;
      rsp_status_in       = rsp_status_ff;
      rsp_last_result_in  = rsp_last_result_ff;
      if (oob_close) begin
         rsp_valid_in        = 1'b1;
         rsp_entry_index_in  = '0;
         rsp_keeps_own_in    = 1'b0;
         rsp_shared_valid_in = 1'b0;
         rsp_shared_in       = '0;
         rsp_repeat_count_in = 6'd1;
         rsp_status_in       = 1'b1;
         rsp_last_result_in  = 1'b1;
      end else if (emit_load) begin
         rsp_valid_in        = 1'b1;
         rsp_entry_index_in  = idx_wide[4:0];
         rsp_keeps_own_in    = cell_present[0] && !(shared && (cell_tuple[0] == best_tuple_ff));
         rsp_shared_valid_in = shared;
         rsp_shared_in       = shared ? best_tuple_ff : '0;
         rsp_repeat_count_in = shared ? rep_wide[5:0] : 6'd1;
         rsp_status_in       = 1'b0;
         rsp_last_result_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= '0;
         best_cnt_ff  <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         best_cnt_ff  <= best_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_tuple_ff       <= best_tuple_in;
      rsp_entry_index_ff  <= rsp_entry_index_in;
      rsp_keeps_own_ff    <= rsp_keeps_own_in;
      rsp_shared_valid_ff <= rsp_shared_valid_in;
      rsp_shared_ff       <= rsp_shared_in;
      rsp_repeat_count_ff <= rsp_repeat_count_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_last_result_ff  <= rsp_last_result_in;
   end

   // ring of cells; each takes from its upper neighbor, the top one from cell 0
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      localparam int NXT = (i + 1) % MAX_ITEMS;
      logic prev_valid;
      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = cell_valid[i-1];
      end
      mmd_cell #(
         .CNT_W (CNT_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .prev_valid   (prev_valid),
         .new_tuple    (req_tuple),
         .new_present  (req_present),
         .nb_tuple     (cell_tuple[NXT]),
         .nb_present   (cell_present[NXT]),
         .nb_tok_tuple (tok_tuple[NXT]),
         .nb_tok_valid (tok_valid[NXT]),
         .nb_tok_cnt   (tok_cnt[NXT]),
         .own_valid    (cell_valid[i]),
         .own_tuple    (cell_tuple[i]),
         .own_present  (cell_present[i]),
         .tok_tuple    (tok_tuple[i]),
         .tok_valid    (tok_valid[i]),
         .tok_cnt      (tok_cnt[i])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_index   = rsp_entry_index_ff;
   assign rsp_keeps_own     = rsp_keeps_own_ff;
   assign rsp_shared_valid  = rsp_shared_valid_ff;
   assign rsp_shared_stamp  = rsp_shared_ff.stamp;
   assign rsp_shared_logger = rsp_shared_ff.logger;
   assign rsp_shared_cell   = rsp_shared_ff.cell_id;
   assign rsp_repeat_count  = rsp_repeat_count_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last_result   = rsp_last_result_ff;

   `MMD_ASSERT_NOW(a_emit_in_range, state_ff == ST_EMIT, step_ff < cnt_ff, "emit index past set size")
   `MMD_ASSERT_NEXT(a_set_done, emit_load && emit_last, state_ff == ST_LOAD && cnt_ff == '0, "set not closed after last result")
   `MMD_ASSERT_NOW(a_best_nonzero, 1'b1, best_cnt_ff != '0, "best count dropped to zero")
   `MMD_ASSERT_NEXT(a_oob_result, oob_close, rsp_valid && rsp_status && rsp_last_result && cnt_ff == '0, "out-of-bounds result missing")

endmodule
`default_nettype wire

// File: rtl/mmd_cell.sv
// One cell of the dedup chain: a stored entry plus a circulating match token.
`default_nettype none
module mmd_cell
   import mmd_pkg::*;
#(
   parameter int CNT_W = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cell_ctrl_type     ctrl,
   input  wire logic              prev_valid,
   input  wire tuple_type         new_tuple,
   input  wire logic              new_present,
   input  wire tuple_type         nb_tuple,
   input  wire logic              nb_present,
   input  wire tuple_type         nb_tok_tuple,
   input  wire logic              nb_tok_valid,
   input  wire logic [CNT_W-1:0]  nb_tok_cnt,
   output      logic              own_valid,
   output      tuple_type         own_tuple,
   output      logic              own_present,
   output      tuple_type         tok_tuple,
   output      logic              tok_valid,
   output      logic [CNT_W-1:0]  tok_cnt
);

   logic             valid_ff, valid_in;
   tuple_type        tuple_ff, tuple_in;
   logic             present_ff, present_in;
   tuple_type        tok_tuple_ff, tok_tuple_in;
   logic             tok_valid_ff, tok_valid_in;
   logic [CNT_W-1:0] tok_cnt_ff, tok_cnt_in;
   logic             take_new;
   logic             match;

   // fill in place: the first empty cell takes the entry
   assign take_new = ctrl.load_req && !valid_ff && prev_valid;
   assign match    = tok_valid_ff && valid_ff && (tok_tuple_ff == tuple_ff);

   always_comb begin
      valid_in     = valid_ff;
      tuple_in     = tuple_ff;
      present_in   = present_ff;
      tok_tuple_in = tok_tuple_ff;
      tok_valid_in = tok_valid_ff;
      tok_cnt_in   = tok_cnt_ff;
      if (ctrl.clear) begin
         valid_in     = 1'b0;
         tok_valid_in = 1'b0;
      end else if (take_new) begin
         valid_in     = 1'b1;
         tuple_in     = new_tuple;
         present_in   = new_present;
         tok_tuple_in = new_tuple;
         tok_valid_in = 1'b1;
         tok_cnt_in   = '0;
      end else if (ctrl.count_en || ctrl.scan_en) begin
         tok_tuple_in = nb_tok_tuple;
         tok_valid_in = nb_tok_valid;
         tok_cnt_in   = nb_tok_cnt;
      end else if (ctrl.shift_en) begin
         tuple_in   = nb_tuple;
         present_in = nb_present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_valid_ff <= tok_valid_in;
      end
      tuple_ff     <= tuple_in;
      present_ff   <= present_in;
      tok_tuple_ff <= tok_tuple_in;
      tok_cnt_ff   <= tok_cnt_in;
   end

   assign own_valid   = valid_ff;
   assign own_tuple   = tuple_ff;
   assign own_present = present_ff;
   assign tok_tuple   = tok_tuple_ff;
   assign tok_valid   = tok_valid_ff;
   assign tok_cnt     = tok_cnt_ff + {{(CNT_W-1){1'b0}}, (ctrl.count_en && match)};

endmodule
`default_nettype wire

// File: tb/metadata_mode_dedup_checker.sv
// Checker for metadata_mode_dedup: predicts the deduplicated results of each set and compares them.
`timescale 1ns / 1ps
`default_nettype none
module mode_dedup_checker
   import mmd_pkg::*;
#(
   parameter int MAX_ITEMS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [31:0] req_stamp,
   input  wire logic [31:0] req_logger,
   input  wire logic [31:0] req_cell_req,
   input  wire logic        req_present,
   input  wire logic        req_last_item,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [4:0]  rsp_entry_index,
   input  wire logic        rsp_keeps_own,
   input  wire logic        rsp_shared_valid,
   input  wire logic [31:0] rsp_shared_stamp,
   input  wire logic [31:0] rsp_shared_logger,
   input  wire logic [31:0] rsp_shared_cell,
   input  wire logic [5:0]  rsp_repeat_count,
   input  wire logic        rsp_status,
   input  wire logic        rsp_last_result,
   output int               failures,
   output int               pending
);

   localparam logic STATUS_OK            = 1'b0;
   localparam logic STATUS_OUT_OF_BOUNDS = 1'b1;

   typedef struct packed {
      logic [4:0] entry_index;
      logic       keeps_own;
      logic       shared_valid;
      tuple_type  shared;
      logic [5:0] repeat_count;
      logic       status;
      logic       last_result;
   } outcome_type;

   tuple_type   held_tuple [MAX_ITEMS];
   logic        held_present [MAX_ITEMS];
   int          held_count;
   logic        overflowed;
   outcome_type due_outcomes [$];

   task automatic report_mismatch(input string msg);
      if (failures < 100) $display("%0t: %s", $time, msg);
      failures++;
   endtask

   task automatic check_field(input int idx, input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("entry %0d %s: got %0h, expected %0h", idx, name, got, want));
   endtask

   // Set closed: queue one outcome per entry for the mode (earliest on ties), or one if overflowed.
   task automatic close_set();
      int          i;
      int          j;
      int          tally;
      int          best_tally;
      int          best_idx;
      logic        shared;
      tuple_type   top_tuple;
      outcome_type r;
      if (overflowed) begin
         r = '0;
         r.repeat_count = 6'd1;
         r.status = STATUS_OUT_OF_BOUNDS;
         r.last_result = 1'b1;
         due_outcomes.push_back(r);
      end else begin
         best_tally = 1;
         best_idx = 0;
         for (i = 0; i < held_count; i++) begin
            tally = 0;
            for (j = 0; j < held_count; j++)
               if (held_tuple[i] == held_tuple[j]) tally++;
            if (tally > best_tally) begin
               best_tally = tally;
               best_idx = i;
            end
         end
         shared = best_tally >= 2;
         top_tuple = shared ? held_tuple[best_idx] : '0;
         for (i = 0; i < held_count; i++) begin
            r.entry_index = 5'(i);
            r.keeps_own = held_present[i] && !(shared && held_tuple[i] == top_tuple);
            r.shared_valid = shared;
            r.shared = top_tuple;
            r.repeat_count = shared ? 6'(best_tally) : 6'd1;
            r.status = STATUS_OK;
            r.last_result = (i == held_count - 1);
            due_outcomes.push_back(r);
         end
      end
      held_count = 0;
      overflowed = 1'b0;
   endtask

   task automatic store_entry();
      if (held_count < MAX_ITEMS) begin
         held_tuple[held_count].stamp = req_stamp;
         held_tuple[held_count].logger = req_logger;
         held_tuple[held_count].cell_id = req_cell_req;
         held_present[held_count] = req_present;
         held_count++;
      end else begin
         overflowed = 1'b1;
      end
      if (req_last_item) close_set();
   endtask

   task automatic match_result();
      outcome_type want;
      if (due_outcomes.size() == 0) begin
         report_mismatch($sformatf("result for entry %0d with none expected", rsp_entry_index));
      end else begin
         want = due_outcomes.pop_front();
         check_field(want.entry_index, "entry_index", rsp_entry_index, want.entry_index);
         check_field(want.entry_index, "keeps_own", rsp_keeps_own, want.keeps_own);
         check_field(want.entry_index, "shared_valid", rsp_shared_valid, want.shared_valid);
         check_field(want.entry_index, "shared_stamp", rsp_shared_stamp, want.shared.stamp);
         check_field(want.entry_index, "shared_logger", rsp_shared_logger, want.shared.logger);
         check_field(want.entry_index, "shared_cell", rsp_shared_cell, want.shared.cell_id);
         check_field(want.entry_index, "repeat_count", rsp_repeat_count, want.repeat_count);
         check_field(want.entry_index, "status", rsp_status, want.status);
         check_field(want.entry_index, "last_result", rsp_last_result, want.last_result);
      end
   endtask

   // Results are matched before the new transaction so a closing set never eats its own results.
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         overflowed = 1'b0;
         due_outcomes.delete();
         failures = 0;
      end else begin
         if (rsp_valid && !rsp_stall) match_result();
         if (req_valid && !req_stall) store_entry();
      end
      pending = due_outcomes.size();
   end

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Top of the metadata_mode_dedup testbench: clock, reset, stimulus, result-side stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench
   import mmd_pkg::*;
();

   localparam int MAX_ITEMS    = 32;
   localparam int RANDOM_ITEMS = 250;
   localparam int MAX_IDLE     = 11;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_stamp;
   logic [31:0] req_logger;
   logic [31:0] req_cell_req;
   logic        req_present;
   logic        req_last_item;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [4:0]  rsp_entry_index;
   logic        rsp_keeps_own;
   logic        rsp_shared_valid;
   logic [31:0] rsp_shared_stamp;
   logic [31:0] rsp_shared_logger;
   logic [31:0] rsp_shared_cell;
   logic [5:0]  rsp_repeat_count;
   logic        rsp_status;
   logic        rsp_last_result;

   int          failures;
   int          pending;
   int          items_sent;
   int          cycle_count;
   logic        sender_idles;
   logic        receiver_idles;

   metadata_mode_dedup #(.MAX_ITEMS(MAX_ITEMS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_stamp(req_stamp),
      .req_logger(req_logger),
      .req_cell_req(req_cell_req),
      .req_present(req_present),
      .req_last_item(req_last_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_entry_index(rsp_entry_index),
      .rsp_keeps_own(rsp_keeps_own),
      .rsp_shared_valid(rsp_shared_valid),
      .rsp_shared_stamp(rsp_shared_stamp),
      .rsp_shared_logger(rsp_shared_logger),
      .rsp_shared_cell(rsp_shared_cell),
      .rsp_repeat_count(rsp_repeat_count),
      .rsp_status(rsp_status),
      .rsp_last_result(rsp_last_result)
   );

   mode_dedup_checker #(.MAX_ITEMS(MAX_ITEMS)) dedup_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_stamp(req_stamp),
      .req_logger(req_logger),
      .req_cell_req(req_cell_req),
      .req_present(req_present),
      .req_last_item(req_last_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_entry_index(rsp_entry_index),
      .rsp_keeps_own(rsp_keeps_own),
      .rsp_shared_valid(rsp_shared_valid),
      .rsp_shared_stamp(rsp_shared_stamp),
      .rsp_shared_logger(rsp_shared_logger),
      .rsp_shared_cell(rsp_shared_cell),
      .rsp_repeat_count(rsp_repeat_count),
      .rsp_status(rsp_status),
      .rsp_last_result(rsp_last_result),
      .failures(failures),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0: random_word = '0;
         1: random_word = '1;
         2: random_word = $urandom_range(0, 3);
         default: random_word = $urandom;
      endcase
   endfunction

   function automatic tuple_type random_tuple();
      tuple_type t;
      t.stamp = random_word();
      t.logger = random_word();
      t.cell_id = random_word();
      return t;
   endfunction

   // Same tuple with one bit of one field flipped: a near miss that must not match.
   function automatic tuple_type near_tuple(input tuple_type t);
      int bit_pos;
      bit_pos = $urandom_range(0, 31);
      case ($urandom_range(0, 2))
         0: t.stamp[bit_pos] = ~t.stamp[bit_pos];
         1: t.logger[bit_pos] = ~t.logger[bit_pos];
         default: t.cell_id[bit_pos] = ~t.cell_id[bit_pos];
      endcase
      return t;
   endfunction

   function automatic int random_set_size();
      case ($urandom_range(0, 15))
         0: random_set_size = MAX_ITEMS;
         1: random_set_size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
         2: random_set_size = $urandom_range(9, MAX_ITEMS - 1);
         default: random_set_size = $urandom_range(1, 8);
      endcase
   endfunction

   // Called and left at a falling edge; valid stays high into the next transaction when no gap.
   task automatic send_entry(input tuple_type t, input logic present, input logic last);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_stamp <= t.stamp;
      req_logger <= t.logger;
      req_cell_req <= t.cell_id;
      req_present <= present;
      req_last_item <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Mostly repeats from a small pool so duplicates, ties and near misses are common.
   task automatic send_random_set(input int n);
      tuple_type pool [4];
      tuple_type t;
      int        pool_size;
      int        pick;
      int        i;
      pool_size = $urandom_range(1, 4);
      for (i = 0; i < 4; i++) pool[i] = random_tuple();
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) t = pool[$urandom_range(0, pool_size - 1)];
         else if (pick < 8) t = near_tuple(pool[$urandom_range(0, pool_size - 1)]);
         else t = random_tuple();
         send_entry(t, 1'($urandom_range(0, 1)), i == n - 1);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int        set_count;
      tuple_type a;
      tuple_type b;
      tuple_type c;
      tuple_type d;
      reset = 1'b1;
      req_valid = 1'b0;
      req_stamp = '0;
      req_logger = '0;
      req_cell_req = '0;
      req_present = 1'b0;
      req_last_item = 1'b0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      items_sent = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // lone entries: nothing to share
      send_entry('0, 1'b0, 1'b1);
      a = '1;
      send_entry(a, 1'b1, 1'b1);
      // identical pair becomes shared metadata
      send_entry(a, 1'b1, 1'b0);
      send_entry(a, 1'b1, 1'b1);
      // two tuples tied at two copies: the earlier one wins
      a = random_tuple();
      b = near_tuple(a);
      send_entry(a, 1'b1, 1'b0);
      send_entry(b, 1'b1, 1'b0);
      send_entry(b, 1'b0, 1'b0);
      send_entry(a, 1'b1, 1'b1);
      // each field differs once: all distinct
      c = random_tuple();
      send_entry(c, 1'b1, 1'b0);
      d = c;
      d.stamp = ~c.stamp;
      send_entry(d, 1'b0, 1'b0);
      d = c;
      d.logger = ~c.logger;
      send_entry(d, 1'b1, 1'b0);
      d = c;
      d.cell_id = ~c.cell_id;
      send_entry(d, 1'b1, 1'b1);
      // a later tuple with more copies takes over the lead
      send_entry(a, 1'b0, 1'b0);
      send_entry(b, 1'b1, 1'b0);
      send_entry(b, 1'b1, 1'b0);
      send_entry(b, 1'b0, 1'b0);
      send_entry(a, 1'b1, 1'b1);

      items_sent = 0;
      // store exactly full, then one entry past it
      send_random_set(MAX_ITEMS);
      send_random_set(MAX_ITEMS + 1);
      set_count = 0;
      while (items_sent < RANDOM_ITEMS) begin
         sender_idles = $urandom_range(0, 3) != 0;
         receiver_idles = $urandom_range(0, 3) != 0;
         if (set_count == 4 || $urandom_range(0, 9) == 0) drain_results();
         send_random_set(random_set_size());
         set_count++;
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (3 * MAX_ITEMS) @(negedge clock);
      if (failures == 0) begin
         $display("** metadata_mode_dedup: PASSED **");
      end else begin
         $display("** metadata_mode_dedup: FAILED **");
      end
      $finish;
   end

   // Result side: random stall before each transaction, with stretches of none.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** metadata_mode_dedup: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/mmd_pkg.sv
rtl/mmd_cell.sv
rtl/metadata_mode_dedup.sv
tb/metadata_mode_dedup_checker.sv
tb/testbench.sv
